FILE: hdl/bbv_pkg.sv
// Shared types, widths, constants and reset values of the buck-boost voltage loop.
package bbv_pkg;

	localparam int ADC_W      = 12;
	localparam int DUTY_W     = 12;
	localparam int GAIN_W     = 16;
	localparam int OFS_W      = 13;
	localparam int PER_W      = 16;
	localparam int CMP_W      = 16;
	localparam int TRIG_W     = 15;
	localparam int ERR_W      = 18;
	localparam int ACC_W      = 32;
	localparam int ACC_FRAC   = 8;
	localparam int Q_FRAC     = 12;
	localparam int CAL_PW     = ADC_W + GAIN_W;
	localparam int SCL_PW     = DUTY_W + PER_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_BUCK  = 2'd1,
		MODE_BOOST = 2'd2,
		MODE_MIX   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_GAIN       = 3'd0,
		REG_CAL_OFFSET     = 3'd1,
		REG_BUCK_MAX_DUTY  = 3'd2,
		REG_BOOST_MAX_DUTY = 3'd3,
		REG_MIN_BUCK_DUTY  = 3'd4,
		REG_BOOST_MIN_DUTY = 3'd5,
		REG_TIMER_PERIOD   = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_ERR,
		ST_PSTART,
		ST_PID,
		ST_SUM1,
		ST_SUM2,
		ST_DUTY,
		ST_SSTART,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADC_W-1:0] adc_sample;
		logic [ADC_W-1:0] voltage_ref;
		mode_t            mode;
		logic             mode_change;
		logic             pwm_enable;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] buck_duty;
		logic [DUTY_W-1:0] boost_duty;
		logic [CMP_W-1:0]  buck_compare;
		logic [TRIG_W-1:0] adc_trigger_compare;
		logic [CMP_W-1:0]  boost_compare;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        cal_gain;
		logic signed [OFS_W-1:0]  cal_offset;
		logic [DUTY_W-1:0]        buck_max_duty;
		logic [DUTY_W-1:0]        boost_max_duty;
		logic [DUTY_W-1:0]        min_buck_duty;
		logic [DUTY_W-1:0]        boost_min_duty;
		logic [PER_W-1:0]         timer_period;
	} cfg_t;

	localparam logic [GAIN_W-1:0]       CAL_GAIN_RST       = 16'd4096;
	localparam logic signed [OFS_W-1:0] CAL_OFFSET_RST     = 13'sd0;
	localparam logic [DUTY_W-1:0]       BUCK_MAX_DUTY_RST  = 12'd3809;
	localparam logic [DUTY_W-1:0]       BOOST_MAX_DUTY_RST = 12'd3809;
	localparam logic [DUTY_W-1:0]       MIN_BUCK_DUTY_RST  = 12'd205;
	localparam logic [DUTY_W-1:0]       BOOST_MIN_DUTY_RST = 12'd205;
	localparam logic [PER_W-1:0]        TIMER_PERIOD_RST   = 16'd20000;

	localparam logic [DUTY_W-1:0] BUCK_DUTY_IN_BOOST_DEF = 12'd3809;
	localparam logic [DUTY_W-1:0] BUCK_DUTY_IN_MIX_DEF   = 12'd3277;
	localparam logic [DUTY_W-1:0] BOOST_DUTY_IN_BUCK_DEF = 12'd287;

	// Q8 loop coefficients
	localparam logic signed [15:0] BK_B0 = 16'sd5203;
	localparam logic signed [15:0] BK_B1 = -16'sd10246;
	localparam logic signed [15:0] BK_B2 = 16'sd5044;
	localparam logic signed [15:0] BS_B0 = 16'sd8860;
	localparam logic signed [15:0] BS_B1 = -16'sd17445;
	localparam logic signed [15:0] BS_B2 = 16'sd8588;

endpackage

FILE: hdl/bbv_in_if.sv
// Sample channel: valid, ready and one input item.
interface bbv_in_if;
	logic               valid;
	logic               ready;
	bbv_pkg::in_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bbv_out_if.sv
// Result channel: valid, ready and one result item.
interface bbv_out_if;
	logic               valid;
	logic               ready;
	bbv_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bbv_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
interface bbv_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bbv_pkg::CFG_IDX_W-1:0]    index;
	logic [bbv_pkg::CFG_DATA_W-1:0]   wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/bbv_smul.sv
// Bit-serial shift-add multiplier with accumulate init, one multiplier bit per cycle.
module bbv_smul #(
	parameter int MW  = 12,
	parameter int PW  = 28,
	parameter bit SGN = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] mplier,
	input  logic [PW-1:0] mcand,
	input  logic [PW-1:0] init,
	output logic          busy,
	output logic [PW-1:0] prod
);
	localparam int CW = (MW > 1) ? $clog2(MW) : 1;
	localparam logic [CW-1:0] LAST = CW'(MW - 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [MW-1:0] mpl_q;
	logic [PW-1:0] mc_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] term;

	assign term = mpl_q[0] ? mc_q : '0;
	assign busy = busy_q;
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// sign bit of a two's complement multiplier weighs negative
	always_ff @(posedge clk) begin
		if (start) begin
			mpl_q <= mplier;
			mc_q  <= mcand;
			acc_q <= init;
		end else if (busy_q) begin
			mpl_q <= mpl_q >> 1;
			mc_q  <= mc_q << 1;
			if (SGN && cnt_q == LAST) begin
				acc_q <= acc_q - term;
			end else begin
				acc_q <= acc_q + term;
			end
		end
	end

endmodule

FILE: hdl/bbv_cfg_regs.sv
// Configuration register file.
module bbv_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	bbv_cfg_if.sink       cfg,
	output bbv_pkg::cfg_t regs
);
	import bbv_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cal_gain       <= CAL_GAIN_RST;
			regs_q.cal_offset     <= CAL_OFFSET_RST;
			regs_q.buck_max_duty  <= BUCK_MAX_DUTY_RST;
			regs_q.boost_max_duty <= BOOST_MAX_DUTY_RST;
			regs_q.min_buck_duty  <= MIN_BUCK_DUTY_RST;
			regs_q.boost_min_duty <= BOOST_MIN_DUTY_RST;
			regs_q.timer_period   <= TIMER_PERIOD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CAL_GAIN:       regs_q.cal_gain       <= cfg.wdata[GAIN_W-1:0];
				REG_CAL_OFFSET:     regs_q.cal_offset     <= cfg.wdata[OFS_W-1:0];
				REG_BUCK_MAX_DUTY:  regs_q.buck_max_duty  <= cfg.wdata[DUTY_W-1:0];
				REG_BOOST_MAX_DUTY: regs_q.boost_max_duty <= cfg.wdata[DUTY_W-1:0];
				REG_MIN_BUCK_DUTY:  regs_q.min_buck_duty  <= cfg.wdata[DUTY_W-1:0];
				REG_BOOST_MIN_DUTY: regs_q.boost_min_duty <= cfg.wdata[DUTY_W-1:0];
				REG_TIMER_PERIOD:   regs_q.timer_period   <= cfg.wdata[PER_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/bbv_core.sv
// Sequencer, loop state and serial datapath of the voltage loop.
module bbv_core #(
	parameter logic [bbv_pkg::DUTY_W-1:0] BUCK_DUTY_IN_BOOST = bbv_pkg::BUCK_DUTY_IN_BOOST_DEF,
	parameter logic [bbv_pkg::DUTY_W-1:0] BUCK_DUTY_IN_MIX   = bbv_pkg::BUCK_DUTY_IN_MIX_DEF,
	parameter logic [bbv_pkg::DUTY_W-1:0] BOOST_DUTY_IN_BUCK = bbv_pkg::BOOST_DUTY_IN_BUCK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbv_pkg::cfg_t      cfg,
	bbv_in_if.sink             sample,
	input  logic               res_free,
	output logic               res_load,
	output bbv_pkg::out_item_t res_data
);
	import bbv_pkg::*;

	localparam int DW = ACC_W - ACC_FRAC;

	state_t   state_q, state_d;
	in_item_t item_q;

	logic signed [ERR_W-1:0] err_q, prev1_q, prev2_q;
	logic [ACC_W-1:0]        acc_q, sum_q;
	logic [DUTY_W-1:0]       held_buck_q, held_boost_q;
	logic [DUTY_W-1:0]       buck_d, boost_d;

	logic accept, cal_start, pid_start, scl_start;
	logic cal_busy, p0_busy, p1_busy, p2_busy, sb_busy, so_busy;

	logic [CAL_PW-1:0] cal_prod;
	logic [ACC_W-1:0]  p0_prod, p1_prod, p2_prod;
	logic [ACC_W-1:0]  c0, c1, c2, p0_init;
	logic [SCL_PW-1:0] sb_prod, so_prod;
	logic [ERR_W-1:0]  vcal;

	assign accept = sample.valid && sample.ready;

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [ACC_W-1:0] acc,
		input logic [DUTY_W-1:0] maxd, input logic [DUTY_W-1:0] mind);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] hi;
		logic signed [DW-1:0] lo;
		d  = signed'(acc[ACC_W-1:ACC_FRAC]);
		hi = signed'({{(DW-DUTY_W){1'b0}}, maxd});
		lo = signed'({{(DW-DUTY_W){1'b0}}, mind});
		d  = (d > hi) ? hi : d;
		d  = (d < lo) ? lo : d;
		return d[DUTY_W-1:0];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (sample.valid) state_d = ST_CAL;
			ST_CAL:    if (!cal_busy) state_d = ST_ERR;
			ST_ERR:    state_d = (item_q.mode == MODE_START) ? ST_DUTY : ST_PSTART;
			ST_PSTART: state_d = ST_PID;
			ST_PID:    if (!p0_busy) state_d = ST_SUM1;
			ST_SUM1:   state_d = ST_SUM2;
			ST_SUM2:   state_d = ST_DUTY;
			ST_DUTY:   state_d = ST_SSTART;
			ST_SSTART: state_d = ST_SCALE;
			ST_SCALE:  if (!sb_busy) state_d = ST_DONE;
			ST_DONE:   if (res_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		sample.ready = 1'b0;
		pid_start    = 1'b0;
		scl_start    = 1'b0;
		res_load     = 1'b0;
		unique case (state_q)
			ST_IDLE:   sample.ready = 1'b1;
			ST_PSTART: pid_start    = 1'b1;
			ST_SSTART: scl_start    = 1'b1;
			ST_DONE:   res_load     = res_free;
			default: ;
		endcase
	end

	assign cal_start = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= sample.data;
		end
	end

	assign vcal = {{(ERR_W-(CAL_PW-Q_FRAC)){1'b0}}, cal_prod[CAL_PW-1:Q_FRAC]}
		+ {{(ERR_W-OFS_W){cfg.cal_offset[OFS_W-1]}}, cfg.cal_offset};

	always_ff @(posedge clk) begin
		if (state_q == ST_ERR) begin
			err_q <= signed'({{(ERR_W-ADC_W){1'b0}}, item_q.voltage_ref} - vcal);
		end
		if (state_q == ST_SUM1) begin
			sum_q <= p0_prod + p1_prod;
		end
	end

	// coefficient set and accumulator seed
	always_comb begin
		if (item_q.mode == MODE_BUCK) begin
			c0 = ACC_W'(BK_B0);
			c1 = ACC_W'(BK_B1);
			c2 = ACC_W'(BK_B2);
		end else begin
			c0 = ACC_W'(BS_B0);
			c1 = ACC_W'(BS_B1);
			c2 = ACC_W'(BS_B2);
		end
		p0_init = item_q.mode_change ? '0 : acc_q;
	end

	always_comb begin
		case (item_q.mode)
			MODE_START: begin
				buck_d  = held_buck_q;
				boost_d = held_boost_q;
			end
			MODE_BUCK: begin
				buck_d  = clamp_duty(acc_q, cfg.buck_max_duty, cfg.min_buck_duty);
				boost_d = BOOST_DUTY_IN_BUCK;
			end
			MODE_BOOST: begin
				buck_d  = BUCK_DUTY_IN_BOOST;
				boost_d = clamp_duty(acc_q, cfg.boost_max_duty, cfg.boost_min_duty);
			end
			default: begin
				buck_d  = BUCK_DUTY_IN_MIX;
				boost_d = clamp_duty(acc_q, cfg.boost_max_duty, cfg.boost_min_duty);
			end
		endcase
		if (!item_q.pwm_enable) begin
			buck_d = cfg.min_buck_duty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			prev1_q      <= '0;
			prev2_q      <= '0;
			held_buck_q  <= MIN_BUCK_DUTY_RST;
			held_boost_q <= BOOST_MIN_DUTY_RST;
		end else begin
			if (state_q == ST_SUM2) begin
				acc_q   <= sum_q + p2_prod;
				prev2_q <= prev1_q;
				prev1_q <= err_q;
			end
			if (state_q == ST_DUTY) begin
				held_buck_q  <= buck_d;
				held_boost_q <= boost_d;
				if (item_q.mode == MODE_START) begin
					acc_q   <= '0;
					prev1_q <= '0;
					prev2_q <= '0;
				end
			end
		end
	end

	bbv_smul #(.MW(ADC_W), .PW(CAL_PW), .SGN(1'b0)) u_cal (
		.clk(clk), .arst_n(arst_n), .start(cal_start),
		.mplier(sample.data.adc_sample),
		.mcand({{(CAL_PW-GAIN_W){1'b0}}, cfg.cal_gain}),
		.init('0), .busy(cal_busy), .prod(cal_prod)
	);

	bbv_smul #(.MW(ERR_W), .PW(ACC_W), .SGN(1'b1)) u_p0 (
		.clk(clk), .arst_n(arst_n), .start(pid_start),
		.mplier(err_q), .mcand(c0), .init(p0_init),
		.busy(p0_busy), .prod(p0_prod)
	);

	bbv_smul #(.MW(ERR_W), .PW(ACC_W), .SGN(1'b1)) u_p1 (
		.clk(clk), .arst_n(arst_n), .start(pid_start),
		.mplier(prev1_q), .mcand(c1), .init('0),
		.busy(p1_busy), .prod(p1_prod)
	);

	bbv_smul #(.MW(ERR_W), .PW(ACC_W), .SGN(1'b1)) u_p2 (
		.clk(clk), .arst_n(arst_n), .start(pid_start),
		.mplier(prev2_q), .mcand(c2), .init('0),
		.busy(p2_busy), .prod(p2_prod)
	);

	bbv_smul #(.MW(DUTY_W), .PW(SCL_PW), .SGN(1'b0)) u_sbuck (
		.clk(clk), .arst_n(arst_n), .start(scl_start),
		.mplier(held_buck_q),
		.mcand({{(SCL_PW-PER_W){1'b0}}, cfg.timer_period}),
		.init('0), .busy(sb_busy), .prod(sb_prod)
	);

	bbv_smul #(.MW(DUTY_W), .PW(SCL_PW), .SGN(1'b0)) u_sboost (
		.clk(clk), .arst_n(arst_n), .start(scl_start),
		.mplier(held_boost_q),
		.mcand({{(SCL_PW-PER_W){1'b0}}, cfg.timer_period}),
		.init('0), .busy(so_busy), .prod(so_prod)
	);

	always_comb begin
		res_data.buck_duty           = held_buck_q;
		res_data.boost_duty          = held_boost_q;
		res_data.buck_compare        = sb_prod[SCL_PW-1:Q_FRAC];
		res_data.adc_trigger_compare = sb_prod[SCL_PW-1:Q_FRAC+1];
		res_data.boost_compare       = cfg.timer_period - so_prod[SCL_PW-1:Q_FRAC];
	end

	a_accept_cal: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CAL)
		else $error("accepted sample did not start calibration");

	a_pid_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PID) |-> (p0_busy == p1_busy && p1_busy == p2_busy))
		else $error("loop multipliers out of step");

	a_scale_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> (sb_busy == so_busy))
		else $error("compare multipliers out of step");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUTY && item_q.mode == MODE_START)
		|=> (acc_q == '0 && prev1_q == '0 && prev2_q == '0))
		else $error("start mode left loop history");

	a_pwm_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUTY && !item_q.pwm_enable)
		|=> held_buck_q == $past(cfg.min_buck_duty))
		else $error("disabled PWM did not force minimum buck duty");

endmodule

FILE: hdl/buck_boost_voltage_pid_top.sv
// Top level of the buck-boost voltage loop: config registers, loop core, result register.
// A sample passes the bit-serial multipliers for calibration, loop filter and compare
// scaling (12-, 18- and 12-bit multipliers); start mode skips the loop filter step.
// A new sample is taken only while the core is idle, after its last result was loaded;
// the next sample is taken while a finished result waits in the output register.
// Reset: asynchronous, clears history and accumulator, held duties to their minimums.
module buck_boost_voltage_pid_top #(
	parameter logic [bbv_pkg::DUTY_W-1:0] BUCK_DUTY_IN_BOOST = bbv_pkg::BUCK_DUTY_IN_BOOST_DEF,
	parameter logic [bbv_pkg::DUTY_W-1:0] BUCK_DUTY_IN_MIX   = bbv_pkg::BUCK_DUTY_IN_MIX_DEF,
	parameter logic [bbv_pkg::DUTY_W-1:0] BOOST_DUTY_IN_BUCK = bbv_pkg::BOOST_DUTY_IN_BUCK_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bbv_in_if.sink    sample,
	bbv_out_if.source result,
	bbv_cfg_if.sink   cfg
);
	import bbv_pkg::*;

	cfg_t      regs;
	out_item_t res_data;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      res_free;
	logic      res_load;

	assign res_free     = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	bbv_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs)
	);

	bbv_core #(
		.BUCK_DUTY_IN_BOOST(BUCK_DUTY_IN_BOOST),
		.BUCK_DUTY_IN_MIX(BUCK_DUTY_IN_MIX),
		.BOOST_DUTY_IN_BUCK(BOOST_DUTY_IN_BUCK)
	) u_core (
		.clk(clk), .arst_n(arst_n), .cfg(regs), .sample(sample),
		.res_free(res_free), .res_load(res_load), .res_data(res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= res_data;
		end
	end

endmodule

FILE: test/buck_boost_voltage_pid_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the buck-boost voltage loop: directed and random samples scored by a predictor.
module buck_boost_voltage_pid_top_tb;
	import bbv_pkg::*;

	localparam int RAND_PHASES   = 8;
	localparam int PHASE_SAMPLES = 200;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 120;
	localparam int MAX_REPORTS   = 10;

	logic clk;
	logic arst_n;

	bbv_in_if  sample ();
	bbv_out_if result ();
	bbv_cfg_if cfg ();

	buck_boost_voltage_pid_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	// predictor copy of the registers
	logic [GAIN_W-1:0]       gain_q     = CAL_GAIN_RST;
	logic signed [OFS_W-1:0] ofs_q      = CAL_OFFSET_RST;
	logic [DUTY_W-1:0]       buck_max_q = BUCK_MAX_DUTY_RST;
	logic [DUTY_W-1:0]       boost_max_q = BOOST_MAX_DUTY_RST;
	logic [DUTY_W-1:0]       buck_min_q = MIN_BUCK_DUTY_RST;
	logic [DUTY_W-1:0]       boost_min_q = BOOST_MIN_DUTY_RST;
	logic [PER_W-1:0]        period_q   = TIMER_PERIOD_RST;

	// predictor copy of the loop state
	int                err_z1     = 0;
	int                err_z2     = 0;
	logic [ACC_W-1:0]  loop_acc   = '0;
	logic [DUTY_W-1:0] hold_buck  = MIN_BUCK_DUTY_RST;
	logic [DUTY_W-1:0] hold_boost = BOOST_MIN_DUTY_RST;

	in_item_t  batch[$];
	in_item_t  pending_samples[$];
	out_item_t expected_results[$];
	out_item_t want;
	mode_t     gen_mode = MODE_BUCK;

	bit          quiet = 1'b0;
	bit          in_beat = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	int unsigned stall_count = 0;

	int n_samples = 0;
	int n_checked = 0;
	int n_bad = 0;
	int n_start = 0;
	int n_pwm_off = 0;
	int n_settings = 0;
	int acc_wraps = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_CAL_GAIN:       gain_q = v[GAIN_W-1:0];
			REG_CAL_OFFSET:     ofs_q = $signed(v[OFS_W-1:0]);
			REG_BUCK_MAX_DUTY:  buck_max_q = v[DUTY_W-1:0];
			REG_BOOST_MAX_DUTY: boost_max_q = v[DUTY_W-1:0];
			REG_MIN_BUCK_DUTY:  buck_min_q = v[DUTY_W-1:0];
			REG_BOOST_MIN_DUTY: boost_min_q = v[DUTY_W-1:0];
			REG_TIMER_PERIOD:   period_q = v[PER_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [ACC_W-1:0] pid_acc(int e, int b0, int b1, int b2);
		longint           t0, t1, t2, wide;
		logic [ACC_W-1:0] s;
		t0 = longint'(e) * b0;
		t1 = longint'(err_z1) * b1;
		t2 = longint'(err_z2) * b2;
		s = loop_acc + t0[31:0] + t1[31:0] + t2[31:0];
		wide = longint'($signed(loop_acc)) + t0 + t1 + t2;
		if (wide != longint'($signed(s)))
			acc_wraps++;
		err_z2 = err_z1;
		err_z1 = e;
		loop_acc = s;
		return s;
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(logic [ACC_W-1:0] acc,
			logic [DUTY_W-1:0] hi, logic [DUTY_W-1:0] lo);
		int d;
		d = $signed(acc) >>> ACC_FRAC;
		if (d > int'(hi))
			d = int'(hi);
		if (d < int'(lo))
			d = int'(lo);
		return d[DUTY_W-1:0];
	endfunction

	function automatic out_item_t loop_step(in_item_t it);
		int                vcal, err;
		logic [31:0]       bc, bscaled;
		logic [DUTY_W-1:0] buck, boost;
		out_item_t         r;
		vcal = int'((32'(it.adc_sample) * 32'(gain_q)) >> Q_FRAC) + int'(ofs_q);
		err = int'(it.voltage_ref) - vcal;
		buck = hold_buck;
		boost = hold_boost;
		if (it.mode_change)
			loop_acc = '0;
		case (it.mode)
			MODE_START: begin
				err_z1 = 0;
				err_z2 = 0;
				loop_acc = '0;
			end
			MODE_BUCK: begin
				buck = clamp_duty(pid_acc(err, BK_B0, BK_B1, BK_B2), buck_max_q, buck_min_q);
				boost = BOOST_DUTY_IN_BUCK_DEF;
			end
			MODE_BOOST: begin
				boost = clamp_duty(pid_acc(err, BS_B0, BS_B1, BS_B2), boost_max_q, boost_min_q);
				buck = BUCK_DUTY_IN_BOOST_DEF;
			end
			default: begin
				boost = clamp_duty(pid_acc(err, BS_B0, BS_B1, BS_B2), boost_max_q, boost_min_q);
				buck = BUCK_DUTY_IN_MIX_DEF;
			end
		endcase
		if (!it.pwm_enable)
			buck = buck_min_q;
		hold_buck = buck;
		hold_boost = boost;
		bc = (32'(buck) * 32'(period_q)) >> Q_FRAC;
		bscaled = 32'(period_q) - ((32'(boost) * 32'(period_q)) >> Q_FRAC);
		r.buck_duty = buck;
		r.boost_duty = boost;
		r.buck_compare = bc[CMP_W-1:0];
		r.adc_trigger_compare = bc[TRIG_W:1];
		r.boost_compare = bscaled[CMP_W-1:0];
		return r;
	endfunction

	function automatic void add_sample(int adc, int vref, mode_t m, bit chg, bit en);
		in_item_t s;
		s.adc_sample = 12'(adc);
		s.voltage_ref = 12'(vref);
		s.mode = m;
		s.mode_change = chg;
		s.pwm_enable = en;
		batch.push_back(s);
	endfunction

	// mostly runs of one mode with a tracking sample; mode switches, start steps and noise mixed in
	function automatic in_item_t next_sample();
		in_item_t s;
		int       d;
		s.mode_change = 1'b0;
		if ($urandom_range(0, 39) == 0) begin
			gen_mode = mode_t'($urandom_range(1, 3));
			s.mode_change = ($urandom_range(0, 4) != 0);
		end
		s.mode = ($urandom_range(0, 49) == 0) ? MODE_START : gen_mode;
		if ($urandom_range(0, 29) == 0)
			s.mode_change = ~s.mode_change;
		s.pwm_enable = ($urandom_range(0, 9) != 0);
		s.voltage_ref = 12'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			d = int'(s.voltage_ref) + int'($urandom_range(0, 80)) - 40;
			if (d < 0)
				d = 0;
			if (d > 4095)
				d = 4095;
			s.adc_sample = 12'(d);
		end else begin
			s.adc_sample = 12'($urandom);
		end
		return s;
	endfunction

	function automatic int unsigned pick_reg(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg.index <= idx;
		cfg.wdata <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, v);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic program_cfg(int unsigned gain, int ofs, int unsigned bmax, int unsigned smax,
			int unsigned bmin, int unsigned smin, int unsigned per);
		write_reg(REG_CAL_GAIN, 16'(gain));
		write_reg(REG_CAL_OFFSET, {3'b000, 13'(ofs)});
		write_reg(REG_BUCK_MAX_DUTY, 16'(bmax));
		write_reg(REG_BOOST_MAX_DUTY, 16'(smax));
		write_reg(REG_MIN_BUCK_DUTY, 16'(bmin));
		write_reg(REG_BOOST_MIN_DUTY, 16'(smin));
		write_reg(REG_TIMER_PERIOD, 16'(per));
		n_settings++;
	endtask

	// hand the staged samples to the driver, then hold off until every result is back
	task automatic flush_batch();
		@(posedge clk);
		foreach (batch[i])
			pending_samples.push_back(batch[i]);
		batch.delete();
		do @(posedge clk);
		while (pending_samples.size() != 0 || sample.valid || n_checked != n_samples);
	endtask

	// sample driver
	always @(negedge clk) begin
		if (arst_n && (!sample.valid || in_beat)) begin
			if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				sample.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				if (!quiet && $urandom_range(0, 3) == 0) begin
					in_gap <= $urandom_range(0, 3);
					sample.valid <= 1'b0;
				end else begin
					sample.data <= pending_samples.pop_front();
					sample.valid <= 1'b1;
				end
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				result.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_gap <= $urandom_range(0, 3);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		in_beat <= sample.valid && sample.ready;
		if (arst_n) begin
			if (sample.valid && sample.ready) begin
				expected_results.push_back(loop_step(sample.data));
				n_samples <= n_samples + 1;
				if (sample.data.mode == MODE_START)
					n_start <= n_start + 1;
				if (!sample.data.pwm_enable)
					n_pwm_off <= n_pwm_off + 1;
			end
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					if (n_bad < MAX_REPORTS)
						$display("result beat with nothing expected: buck %0d boost %0d",
							result.data.buck_duty, result.data.boost_duty);
					n_bad <= n_bad + 1;
				end else begin
					want = expected_results.pop_front();
					n_checked <= n_checked + 1;
					if (want.buck_duty !== result.data.buck_duty ||
							want.boost_duty !== result.data.boost_duty ||
							want.buck_compare !== result.data.buck_compare ||
							want.adc_trigger_compare !== result.data.adc_trigger_compare ||
							want.boost_compare !== result.data.boost_compare) begin
						if (n_bad < MAX_REPORTS) begin
							$display("result %0d mismatch: expected buck %0d boost %0d cmp %0d trig %0d bcmp %0d",
								n_checked, want.buck_duty, want.boost_duty, want.buck_compare,
								want.adc_trigger_compare, want.boost_compare);
							$display("  got buck %0d boost %0d cmp %0d trig %0d bcmp %0d",
								result.data.buck_duty, result.data.boost_duty,
								result.data.buck_compare, result.data.adc_trigger_compare,
								result.data.boost_compare);
						end
						n_bad <= n_bad + 1;
					end
				end
			end
		end
	end

	// watchdog: cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (sample.valid && sample.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready)) begin
			stall_count <= 0;
		end else if (stall_count == STALL_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.data = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_CAL_GAIN;
		cfg.wdata = '0;
		gen_mode = mode_t'($urandom_range(1, 3));
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: every mode, field extremes, PWM off, held duties in start mode
		add_sample(2048, 2048, MODE_START, 1'b0, 1'b1);
		add_sample(0, 4095, MODE_BUCK, 1'b0, 1'b1);
		add_sample(4095, 0, MODE_BUCK, 1'b0, 1'b1);
		add_sample(2000, 2100, MODE_BUCK, 1'b0, 1'b0);
		add_sample(2000, 2100, MODE_BOOST, 1'b1, 1'b1);
		add_sample(2100, 2000, MODE_BOOST, 1'b0, 1'b1);
		add_sample(1000, 1500, MODE_MIX, 1'b1, 1'b1);
		add_sample(1500, 1000, MODE_MIX, 1'b0, 1'b0);
		add_sample(4095, 4095, MODE_START, 1'b0, 1'b1);
		add_sample(0, 0, MODE_BUCK, 1'b1, 1'b1);
		flush_batch();

		// full gain, lowest offset: alternating boost and buck steps wrap the accumulator
		program_cfg(65535, -4096, 4095, 4095, 0, 0, 65535);
		add_sample(0, 0, MODE_START, 1'b1, 1'b1);
		for (int i = 0; i < 6; i++) begin
			add_sample(0, 4095, MODE_BOOST, 1'b0, 1'b1);
			add_sample(4095, 0, MODE_BUCK, 1'b0, 1'b1);
		end
		flush_batch();

		// zero gain, minimums above maximums, zero period
		program_cfg(0, 4095, 100, 0, 3000, 4095, 0);
		add_sample(4095, 0, MODE_BUCK, 1'b1, 1'b1);
		add_sample(0, 4095, MODE_BOOST, 1'b0, 1'b1);
		add_sample(2048, 1, MODE_MIX, 1'b0, 1'b0);
		flush_batch();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1) begin
				quiet = 1'b1;
				program_cfg(CAL_GAIN_RST, CAL_OFFSET_RST, BUCK_MAX_DUTY_RST, BOOST_MAX_DUTY_RST,
					MIN_BUCK_DUTY_RST, BOOST_MIN_DUTY_RST, TIMER_PERIOD_RST);
			end else if (p % 2 == 0) begin
				program_cfg($urandom_range(3800, 4400), int'($urandom_range(0, 128)) - 64,
					$urandom_range(2048, 4095), $urandom_range(2048, 4095),
					$urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(1000, 65535));
			end else begin
				program_cfg(pick_reg(0, 65535), int'(pick_reg(0, 8191)) - 4096,
					pick_reg(0, 4095), pick_reg(0, 4095), pick_reg(0, 4095), pick_reg(0, 4095),
					pick_reg(1, 65535));
			end
			for (int i = 0; i < PHASE_SAMPLES; i++)
				batch.push_back(next_sample());
			flush_batch();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d samples under %0d register settings: %0d start steps, %0d with PWM off.",
			n_samples, n_settings, n_start, n_pwm_off);
		$display("Checked %0d results; predictor saw %0d accumulator wraps; %0d mismatches.",
			n_checked, acc_wraps, n_bad);
		if (n_bad == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
